// ===== src/g2j_pkg.sv =====
// Shared constants and lookup functions for the Gregorian to Jalali date converter.
`default_nettype none

package g2j_pkg;

    localparam int unsigned STAGES = 9;

    localparam logic [11:0] EPOCH_YEAR    = 12'd1600;
    localparam logic [11:0] JAL_YEAR_BASE = 12'd946;
    localparam logic [13:0] DAY_OFFSET    = 14'd11973;
    localparam logic [19:0] CYCLE_DAYS    = 20'd12053;
    localparam logic [13:0] GROUP_DAYS    = 14'd1461;
    localparam logic [19:0] YEAR_DAYS     = 20'd365;

    localparam logic [12:0] RECIP_100     = 13'd5243;
    localparam logic [20:0] RECIP_CYCLE   = 21'd1425361;
    localparam logic [27:0] RECIP_GROUP   = 28'd11484;

    localparam logic [3:0]  MONTH_LAST    = 4'd11;

    function automatic logic [8:0] greg_before(input logic [3:0] month);
        logic [8:0] days;
        begin
            case (month)
                4'd1:    days = 9'd0;
                4'd2:    days = 9'd31;
                4'd3:    days = 9'd59;
                4'd4:    days = 9'd90;
                4'd5:    days = 9'd120;
                4'd6:    days = 9'd151;
                4'd7:    days = 9'd181;
                4'd8:    days = 9'd212;
                4'd9:    days = 9'd243;
                4'd10:   days = 9'd273;
                4'd11:   days = 9'd304;
                4'd12:   days = 9'd334;
                default: days = 9'd0;
            endcase
            greg_before = days;
        end
    endfunction

    function automatic logic [8:0] jal_start(input logic [3:0] idx);
        logic [8:0] days;
        begin
            case (idx)
                4'd0:    days = 9'd0;
                4'd1:    days = 9'd31;
                4'd2:    days = 9'd62;
                4'd3:    days = 9'd93;
                4'd4:    days = 9'd124;
                4'd5:    days = 9'd155;
                4'd6:    days = 9'd186;
                4'd7:    days = 9'd216;
                4'd8:    days = 9'd246;
                4'd9:    days = 9'd276;
                4'd10:   days = 9'd306;
                4'd11:   days = 9'd336;
                default: days = 9'd0;
            endcase
            jal_start = days;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/gregorian_to_jalali_date.sv =====
// Nine-stage pipelined Gregorian to Jalali date converter.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------------
//  input   | in_valid  | in_stall  | greg_year, greg_month, greg_day
//  output  | out_valid | out_stall | jal_year, jal_month, jal_day, bad_input
//
// One transfer per cycle sustained while out_stall is low; the stages carry the chain of
// reciprocal multiplies for the 33-year cycle and 4-year group splits.
// Reset clears only the stage valid bits.
// A stall at the output holds the last stage; empty stages upstream keep
// filling, and in_stall rises only once stage one holds an item that cannot move.
`default_nettype none

module gregorian_to_jalali_date (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [11:0] greg_year,
    input  wire logic [3:0]  greg_month,
    input  wire logic [4:0]  greg_day,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [11:0]      jal_year,
    output logic [3:0]       jal_month,
    output logic [4:0]       jal_day,
    output logic             bad_input
);

    localparam int unsigned NS = g2j_pkg::STAGES;

    logic [NS:1]   valid_reg;
    logic [NS:1]   valid_next;
    logic [NS+1:1] adv;

    // stage payloads
    logic        bad1_reg, bad2_reg, bad3_reg, bad4_reg, bad5_reg, bad6_reg, bad7_reg, bad8_reg;
    logic [11:0] gy1_reg;
    logic [3:0]  mon1_reg;
    logic [9:0]  n4_1_reg;
    logic [4:0]  n100_1_reg;
    logic [2:0]  n400_1_reg;
    logic [19:0] y365_1_reg;
    logic [13:0] doff1_reg, doff2_reg;
    logic [19:0] base2_reg;
    logic        leap2_reg;
    logic [19:0] d3_reg, d4_reg;
    logic [6:0]  cyc4_reg;
    logic [13:0] rem5_reg, rem6_reg;
    logic [11:0] jy5_reg, jy6_reg, jy7_reg, jy8_reg;
    logic [3:0]  grp6_reg;
    logic [10:0] r7_reg;
    logic [8:0]  ry8_reg;
    logic [11:0] jal_year_reg;
    logic [3:0]  jal_month_reg;
    logic [4:0]  jal_day_reg;
    logic        bad_input_reg;

    logic        bad1_next;
    logic [11:0] gy1_next;
    logic [9:0]  n4_1_next;
    logic [4:0]  n100_1_next;
    logic [2:0]  n400_1_next;
    logic [19:0] y365_1_next;
    logic [13:0] doff1_next;
    logic [12:0] gy_p3, gy_p99, gy_p399;
    logic [25:0] p100, p400;

    logic [19:0] base2_next;
    logic        leap2_next;
    logic [19:0] d3_next;
    logic [40:0] pcyc;
    logic [6:0]  cyc4_next;
    logic [13:0] rem5_next;
    logic [11:0] jy5_next;
    logic [27:0] pgrp;
    logic [3:0]  grp6_next;
    logic [10:0] r7_next;
    logic [11:0] jy7_next;
    logic [10:0] t8;
    logic [8:0]  ry8_next;
    logic [11:0] jy8_next;
    logic [3:0]  mcnt;
    logic [8:0]  dday;
    logic [11:0] jal_year_next;
    logic [3:0]  jal_month_next;
    logic [4:0]  jal_day_next;

    // flow control
    always_comb
    begin
        adv[NS+1] = !out_stall;
        for (int i = NS; i >= 1; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next[1] = adv[1] ? in_valid : valid_reg[1];
        for (int i = 2; i <= NS; i++)
        begin
            if (adv[i])
                valid_next[i] = valid_reg[i-1];
            else
                valid_next[i] = valid_reg[i];
        end
    end

    assign in_stall = !adv[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // stage 1: clamp year, leap counts, month offset
    always_comb
    begin
        bad1_next   = (greg_month == 4'd0) || (greg_month > 4'd12) || (greg_day == 5'd0);
        gy1_next    = (greg_year < g2j_pkg::EPOCH_YEAR) ? 12'd0
                                                        : greg_year - g2j_pkg::EPOCH_YEAR;
        gy_p3       = {1'b0, gy1_next} + 13'd3;
        gy_p99      = {1'b0, gy1_next} + 13'd99;
        gy_p399     = {1'b0, gy1_next} + 13'd399;
        p100        = 26'(gy_p99) * 26'(g2j_pkg::RECIP_100);
        p400        = 26'(gy_p399) * 26'(g2j_pkg::RECIP_100);
        n4_1_next   = gy_p3[11:2];
        n100_1_next = p100[23:19];
        n400_1_next = p400[23:21];
        y365_1_next = 20'(gy1_next) * g2j_pkg::YEAR_DAYS;
        doff1_next  = 14'(g2j_pkg::greg_before(greg_month)) + 14'(greg_day)
                      + g2j_pkg::DAY_OFFSET;
    end

    // stage 2: year base and leap day
    always_comb
    begin
        base2_next = y365_1_reg + 20'(n4_1_reg) + 20'(n400_1_reg) - 20'(n100_1_reg);
        leap2_next = (gy1_reg[1:0] == 2'b00)
                     && ((12'(n100_1_reg) * 12'd100 != gy1_reg)
                         || (12'(n400_1_reg) * 12'd400 == gy1_reg))
                     && (mon1_reg > 4'd2);
    end

    // stage 3: shifted day count
    assign d3_next = base2_reg + 20'(doff2_reg) + 20'(leap2_reg);

    // stage 4: 33-year cycle count
    always_comb
    begin
        pcyc      = 41'(d3_reg) * 41'(g2j_pkg::RECIP_CYCLE);
        cyc4_next = pcyc[40:34];
    end

    // stage 5: cycle remainder and year base
    always_comb
    begin
        rem5_next = 14'(d4_reg - 20'(cyc4_reg) * g2j_pkg::CYCLE_DAYS);
        jy5_next  = g2j_pkg::JAL_YEAR_BASE + 12'(cyc4_reg) * 12'd33;
    end

    // stage 6: 4-year group count
    always_comb
    begin
        pgrp      = 28'(rem5_reg) * g2j_pkg::RECIP_GROUP;
        grp6_next = pgrp[27:24];
    end

    // stage 7: group remainder
    always_comb
    begin
        r7_next  = 11'(rem6_reg - 14'(grp6_reg) * g2j_pkg::GROUP_DAYS);
        jy7_next = jy6_reg + {6'd0, grp6_reg, 2'b00};
    end

    // stage 8: year within group
    always_comb
    begin
        t8 = r7_reg - 11'd1;
        if (r7_reg < 11'd366)
        begin
            ry8_next = r7_reg[8:0];
            jy8_next = jy7_reg;
        end
        else if (t8 >= 11'd1095)
        begin
            ry8_next = 9'(t8 - 11'd1095);
            jy8_next = jy7_reg + 12'd3;
        end
        else if (t8 >= 11'd730)
        begin
            ry8_next = 9'(t8 - 11'd730);
            jy8_next = jy7_reg + 12'd2;
        end
        else
        begin
            ry8_next = 9'(t8 - 11'd365);
            jy8_next = jy7_reg + 12'd1;
        end
    end

    // stage 9: month walk
    always_comb
    begin
        mcnt = 4'd0;
        for (int k = 1; k <= 11; k++)
        begin
            if (ry8_reg >= g2j_pkg::jal_start(4'(k)))
                mcnt = mcnt + 4'd1;
        end
        dday = ry8_reg - g2j_pkg::jal_start(mcnt) + 9'd1;
        if (bad8_reg)
        begin
            jal_year_next  = 12'd0;
            jal_month_next = 4'd0;
            jal_day_next   = 5'd0;
        end
        else
        begin
            jal_year_next  = jy8_reg;
            jal_month_next = mcnt + 4'd1;
            jal_day_next   = dday[4:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            bad1_reg   <= bad1_next;
            gy1_reg    <= gy1_next;
            mon1_reg   <= greg_month;
            n4_1_reg   <= n4_1_next;
            n100_1_reg <= n100_1_next;
            n400_1_reg <= n400_1_next;
            y365_1_reg <= y365_1_next;
            doff1_reg  <= doff1_next;
        end
        if (adv[2])
        begin
            bad2_reg  <= bad1_reg;
            base2_reg <= base2_next;
            leap2_reg <= leap2_next;
            doff2_reg <= doff1_reg;
        end
        if (adv[3])
        begin
            bad3_reg <= bad2_reg;
            d3_reg   <= d3_next;
        end
        if (adv[4])
        begin
            bad4_reg <= bad3_reg;
            d4_reg   <= d3_reg;
            cyc4_reg <= cyc4_next;
        end
        if (adv[5])
        begin
            bad5_reg <= bad4_reg;
            rem5_reg <= rem5_next;
            jy5_reg  <= jy5_next;
        end
        if (adv[6])
        begin
            bad6_reg <= bad5_reg;
            rem6_reg <= rem5_reg;
            grp6_reg <= grp6_next;
            jy6_reg  <= jy5_reg;
        end
        if (adv[7])
        begin
            bad7_reg <= bad6_reg;
            r7_reg   <= r7_next;
            jy7_reg  <= jy7_next;
        end
        if (adv[8])
        begin
            bad8_reg <= bad7_reg;
            ry8_reg  <= ry8_next;
            jy8_reg  <= jy8_next;
        end
        if (adv[9])
        begin
            jal_year_reg  <= jal_year_next;
            jal_month_reg <= jal_month_next;
            jal_day_reg   <= jal_day_next;
            bad_input_reg <= bad8_reg;
        end
    end

    assign out_valid = valid_reg[NS];
    assign jal_year  = jal_year_reg;
    assign jal_month = jal_month_reg;
    assign jal_day   = jal_day_reg;
    assign bad_input = bad_input_reg;

`ifndef SYNTH
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_input |-> jal_year == 12'd0 && jal_month == 4'd0 && jal_day == 5'd0)
        else $error("bad input result carries nonzero date");

    a_good_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bad_input |-> jal_month >= 4'd1 && jal_month <= 4'd12
                                     && jal_day >= 5'd1)
        else $error("Jalali month or day out of range");

    a_cycle_rem: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[5] |-> rem5_reg < 14'(g2j_pkg::CYCLE_DAYS))
        else $error("33-year cycle remainder not reduced");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> valid_reg[1])
        else $error("accepted transfer lost at stage one");
`endif

endmodule

`default_nettype wire
